>>> hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and a rotate helper function for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumBlkW = 16;
  localparam int unsigned BlkAW   = 4;
  localparam int unsigned NumRnd  = 64;
  localparam int unsigned RndW    = 6;
  localparam int unsigned FillW   = 6;
  localparam int unsigned LenPos  = 56;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_HASH,
    ST_OUT
  } top_st_t;

  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_RUN,
    CORE_ADD
  } core_st_t;

  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

>>> hw/rtl/sha_ifs.sv
// ----------------------------------------------------------------------------
// sha_ifs
// Valid/ready channel interfaces for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink   (input valid, input digest_word, input word_index, input last_word,
                  output ready);
endinterface

>>> hw/rtl/sha_blkmem.sv
// ----------------------------------------------------------------------------
// sha_blkmem
// 16 x 32-bit block buffer, one write port, one registered read port.
// ----------------------------------------------------------------------------
module sha_blkmem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [sha_pkg::BlkAW-1:0]  wr_addr,
  input  sha_pkg::word_t             wr_data,
  input  logic [sha_pkg::BlkAW-1:0]  rd_addr,
  output sha_pkg::word_t             rd_data
);

  sha_pkg::word_t mem [sha_pkg::NumBlkW];
  sha_pkg::word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/sha_core.sv
// ----------------------------------------------------------------------------
// sha_core
// Compression engine: one round per cycle, message schedule in a 16-word
// window, chaining words held here.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       init,
  output logic [sha_pkg::BlkAW-1:0]  rd_addr,
  input  sha_pkg::word_t             rd_data,
  output logic                       done,
  output sha_pkg::word_t             chain [8]
);

  sha_pkg::core_st_t           st_r, st_nxt;
  logic [sha_pkg::RndW-1:0]    rnd_r, rnd_nxt;
  sha_pkg::word_t              h_r [8];
  sha_pkg::word_t              v_r [8];
  sha_pkg::word_t              w_r [16];
  sha_pkg::word_t              w_cur, s0w, s1w, e1, ch, t1, a0, maj, t2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= sha_pkg::CORE_IDLE;
      rnd_r <= '0;
    end else begin
      st_r  <= st_nxt;
      rnd_r <= rnd_nxt;
    end
  end

  always_comb begin
    st_nxt  = st_r;
    rnd_nxt = rnd_r;
    done    = 1'b0;
    rd_addr = '0;
    case (st_r)
      sha_pkg::CORE_IDLE: begin
        rnd_nxt = '0;
        if (start) begin
          st_nxt = sha_pkg::CORE_RUN;
        end
      end
      sha_pkg::CORE_RUN: begin
        // fetch the next round's block word through the registered read port
        rd_addr = rnd_r[sha_pkg::BlkAW-1:0] + 1'b1;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == sha_pkg::RndW'(sha_pkg::NumRnd - 1)) begin
          st_nxt = sha_pkg::CORE_ADD;
        end
      end
      sha_pkg::CORE_ADD: begin
        done   = 1'b1;
        st_nxt = sha_pkg::CORE_IDLE;
      end
      default: st_nxt = sha_pkg::CORE_IDLE;
    endcase
  end

  always_comb begin
    s0w = sha_pkg::rotr(w_r[1], 7) ^ sha_pkg::rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1w = sha_pkg::rotr(w_r[14], 17) ^ sha_pkg::rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    if (rnd_r < sha_pkg::RndW'(sha_pkg::NumBlkW)) begin
      w_cur = rd_data;
    end else begin
      w_cur = w_r[0] + s0w + w_r[9] + s1w;
    end
    e1  = sha_pkg::rotr(v_r[4], 6) ^ sha_pkg::rotr(v_r[4], 11) ^ sha_pkg::rotr(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1  = v_r[7] + e1 + ch + sha_pkg::K_TAB[rnd_r] + w_cur;
    a0  = sha_pkg::rotr(v_r[0], 2) ^ sha_pkg::rotr(v_r[0], 13) ^ sha_pkg::rotr(v_r[0], 22);
    maj = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2  = a0 + maj;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || init) begin
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::IV_TAB[i];
    end else if (st_r == sha_pkg::CORE_ADD) begin
      for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == sha_pkg::CORE_IDLE && start) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end else if (st_r == sha_pkg::CORE_RUN) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= w_cur;
    end
  end

  assign chain = h_r;

endmodule

>>> hw/rtl/sha256_stream_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher_top
// Streaming SHA-256: message bytes in, eight digest words out per message.
// ----------------------------------------------------------------------------
// in_ch carries one request per message byte (kind 0) or a finish (kind 1).
// bytes are packed big-endian into a 16-word block buffer, accepted back to
// back while idle; every 64th byte starts a compression that holds in_ch.ready
// low through its 64 rounds (one per cycle) and the final chaining add.
// a finish pads the block one byte per cycle outside compressions (0x80, zeros,
// 64-bit bit length), compressing once or twice, then presents eight requests
// on out_ch, h0 first, last_word set on the eighth. in_ch stays low until all
// eight are taken; a stall on out_ch simply holds the current word.
// after the last word the chaining words return to the initial values and the
// length and fill counters clear. reset (rst_n low, synchronous) does the
// same and drops out_ch.valid; the block buffer is not cleared.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_top (
  input  logic      clk,
  input  logic      rst_n,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);

  sha_pkg::top_st_t            st_r, st_nxt;
  logic [sha_pkg::FillW-1:0]   fill_r, fill_nxt;
  logic [63:0]                 len_r, len_nxt;
  logic [23:0]                 acc_r, acc_nxt;
  logic [2:0]                  idx_r, idx_nxt;
  logic                        fin_r, fin_nxt;
  logic                        first_r, first_nxt;
  logic                        extra_r, extra_nxt;

  logic                        push;
  logic [7:0]                  push_byte;
  logic                        mem_we;
  logic                        core_start, core_init, core_done;
  logic [sha_pkg::BlkAW-1:0]   core_raddr;
  sha_pkg::word_t              core_rdata;
  sha_pkg::word_t              chain [8];
  logic [63:0]                 bit_len;
  logic [2:0]                  len_sel;

  sha_blkmem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (fill_r[sha_pkg::FillW-1:2]),
    .wr_data ({acc_r, push_byte}),
    .rd_addr (core_raddr),
    .rd_data (core_rdata)
  );

  sha_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (core_start),
    .init    (core_init),
    .rd_addr (core_raddr),
    .rd_data (core_rdata),
    .done    (core_done),
    .chain   (chain)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= sha_pkg::ST_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      idx_r   <= '0;
      fin_r   <= 1'b0;
      first_r <= 1'b0;
      extra_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      fin_r   <= fin_nxt;
      first_r <= first_nxt;
      extra_r <= extra_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  assign bit_len = {len_r[60:0], 3'b000};
  assign len_sel = ~fill_r[2:0];

  always_comb begin
    st_nxt     = st_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    fin_nxt    = fin_r;
    first_nxt  = first_r;
    extra_nxt  = extra_r;
    push       = 1'b0;
    push_byte  = in_ch.data_byte;
    core_start = 1'b0;
    core_init  = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;

    case (st_r)
      sha_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (in_ch.kind) begin
            st_nxt    = sha_pkg::ST_PAD;
            fin_nxt   = 1'b1;
            first_nxt = 1'b1;
          end else begin
            push    = 1'b1;
            len_nxt = len_r + 64'd1;
          end
        end
      end
      sha_pkg::ST_PAD: begin
        push = 1'b1;
        if (first_r) begin
          push_byte = sha_pkg::PAD_BYTE;
          first_nxt = 1'b0;
          if (fill_r >= sha_pkg::FillW'(sha_pkg::LenPos)) begin
            extra_nxt = 1'b1;
          end
        end else if (!extra_r && fill_r >= sha_pkg::FillW'(sha_pkg::LenPos)) begin
          push_byte = bit_len[{len_sel, 3'b000} +: 8];
        end else begin
          push_byte = 8'h00;
        end
      end
      sha_pkg::ST_HASH: begin
        if (core_done) begin
          if (!fin_r) begin
            st_nxt = sha_pkg::ST_IDLE;
          end else if (extra_r) begin
            // length goes in a second block
            extra_nxt = 1'b0;
            st_nxt    = sha_pkg::ST_PAD;
          end else begin
            idx_nxt = '0;
            st_nxt  = sha_pkg::ST_OUT;
          end
        end
      end
      sha_pkg::ST_OUT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r == 3'd7) begin
            core_init = 1'b1;
            len_nxt   = '0;
            fin_nxt   = 1'b0;
            st_nxt    = sha_pkg::ST_IDLE;
          end
        end
      end
      default: st_nxt = sha_pkg::ST_IDLE;
    endcase

    if (push) begin
      fill_nxt = fill_r + 1'b1;
      if (fill_r == '1) begin
        core_start = 1'b1;
        st_nxt     = sha_pkg::ST_HASH;
      end
    end
  end

  assign acc_nxt = push ? {acc_r[15:0], push_byte} : acc_r;
  assign mem_we  = push && (fill_r[1:0] == 2'b11);

  assign out_ch.digest_word = chain[idx_r];
  assign out_ch.word_index  = idx_r;
  assign out_ch.last_word   = (idx_r == 3'd7);

endmodule
